FILE: hw/rtl/cxr_pkg.sv
// Shared types, widths and constants of the XYZ to RGB converter.
// No dependencies; every other file imports it.
package cxr_pkg;

    localparam int CHROMA_W = 16;
    localparam int NUM_REGS = 8;
    localparam int IDX_W    = 3;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;
    localparam int IN_W     = 18;
    localparam int OUT_W    = 21;
    localparam int COEF_W   = 32;
    localparam int NUM_COEF = 9;
    localparam int K_W      = 4;

    // Derivation arithmetic: chromaticity z, cofactor, product and divider widths.
    localparam int Z_W    = 18;
    localparam int COF_W  = 36;
    localparam int PROD_W = 54;
    localparam int A_W    = 50;
    localparam int D_W    = 53;

    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

    localparam logic [IDX_W-1:0] REG_RED_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RED_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_GREEN_X = 3'd2;
    localparam logic [IDX_W-1:0] REG_GREEN_Y = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLUE_X  = 3'd4;
    localparam logic [IDX_W-1:0] REG_BLUE_Y  = 3'd5;
    localparam logic [IDX_W-1:0] REG_WHITE_X = 3'd6;
    localparam logic [IDX_W-1:0] REG_WHITE_Y = 3'd7;

    typedef logic [NUM_REGS-1:0][CHROMA_W-1:0] cfg_regs_t;
    typedef logic [NUM_COEF-1:0][COEF_W-1:0] matrix_t;

    // Rec.709 primaries with a D65 white.
    localparam cfg_regs_t CFG_RESET = {
        16'd21561, 16'd20493, 16'd3932, 16'd9830,
        16'd39322, 16'd19661, 16'd21627, 16'd41943
    };

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_SAT   = 2'd1,
        STATUS_DEGEN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        DER_COF,
        DER_RESP,
        DER_CHECK,
        DER_NUM,
        DER_DIV,
        DER_FIN,
        DER_DONE
    } der_state_t;

    typedef struct packed {
        logic busy;
        logic degenerate;
    } der_stat_t;

endpackage

FILE: hw/rtl/cie_xyz_to_rgb_converter.sv
// CIE XYZ to linear RGB converter, top level; uses cxr_pkg, cxr_cfg_regs,
// cxr_matrix_derive and cxr_pipe.
// A request passes the product, sum and output registers; one request per cycle
// is taken while m_axis_tready is high. After reset and after every register write the
// matrix is rederived by the shared multiplier and the one-bit-per-cycle divider, with
// the division skipped for a degenerate system; s_axis_tready stays low meanwhile.
// Reset is asynchronous and active low and loads Rec.709 primaries with a D65 white.
module cie_xyz_to_rgb_converter
    import cxr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [55:0]       s_axis_tdata,   // cie_x, cie_y, cie_z, two zero bits
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [63:0]       m_axis_tdata,   // red_out, green_out, blue_out, one zero bit
    output logic [1:0]        m_axis_tuser    // status
);

    cfg_regs_t  regs;
    logic       cfg_wr;
    matrix_t    matrix;
    der_stat_t  stat;
    status_t    status;
    logic signed [OUT_W-1:0] red_out;
    logic signed [OUT_W-1:0] green_out;
    logic signed [OUT_W-1:0] blue_out;

    cxr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs),
        .cfg_wr  (cfg_wr)
    );

    cxr_matrix_derive #(
        .FRAC_BITS (FRAC_BITS)
    ) u_derive (
        .clk    (clk),
        .rst_n  (rst_n),
        .regs   (regs),
        .cfg_wr (cfg_wr),
        .matrix (matrix),
        .stat   (stat)
    );

    cxr_pipe #(
        .FRAC_BITS (FRAC_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .matrix    (matrix),
        .stat      (stat),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .cie_x     (s_axis_tdata[17:0]),
        .cie_y     (s_axis_tdata[35:18]),
        .cie_z     (s_axis_tdata[53:36]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .status    (status)
    );

    assign m_axis_tdata = {1'b0, blue_out, green_out, red_out};
    assign m_axis_tuser = status;

endmodule

FILE: hw/rtl/cxr_cfg_regs.sv
// Configuration register file with its APB-style access port.
// Depends on cxr_pkg.
module cxr_cfg_regs
    import cxr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_regs_t         regs,
    output logic              cfg_wr
);

    cfg_regs_t        regs_reg;
    logic [IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = {{(APB_W-CHROMA_W){1'b0}}, regs_reg[idx]};
    assign regs   = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= CFG_RESET;
        end
        else if (cfg_wr)
        begin
            regs_reg[idx] <= pwdata[CHROMA_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/cxr_matrix_derive.sv
// Sequencer that derives the white-scaled conversion matrix from the primaries,
// using one shared multiplier and a restoring divider. Depends on cxr_pkg.
module cxr_matrix_derive
    import cxr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_regs_t regs,
    input  logic      cfg_wr,
    output matrix_t   matrix,
    output der_stat_t stat
);

    localparam int NW    = A_W + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(NW);
    localparam int W1    = 33 + FRAC_BITS;
    localparam logic [W1-1:0] POS_LIM = W1'(64'h7FFF_FFFF);
    localparam logic [W1-1:0] NEG_LIM = W1'(64'h8000_0000);
    localparam logic signed [Z_W-1:0] CHROMA_ONE = Z_W'(65536);

    der_state_t state_reg;
    der_state_t state_next;

    logic [K_W-1:0]   k_reg;
    logic [1:0]       row_reg;
    logic [1:0]       col_reg;
    logic             sub_reg;
    logic             half_reg;
    logic [CNT_W-1:0] bit_cnt_reg;
    logic             degen_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [COF_W-1:0]  cof_reg [NUM_COEF];
    logic signed [PROD_W-1:0] resp_reg [3];
    logic [NW-1:0]            nq_reg;
    logic [D_W-1:0]           rem_reg;
    logic [D_W-1:0]           d_reg;
    logic                     neg_reg;
    matrix_t                  coef_reg;

    logic signed [Z_W-1:0] px_s [3];
    logic signed [Z_W-1:0] py_s [3];
    logic signed [Z_W-1:0] pz_s [3];
    logic signed [Z_W-1:0] w_s [3];
    logic [1:0]            ia;
    logic [1:0]            ib;
    logic signed [Z_W-1:0] u_a;
    logic signed [Z_W-1:0] u_b;
    logic signed [Z_W-1:0] v_a;
    logic signed [Z_W-1:0] v_b;
    logic signed [COF_W-1:0]  op_a;
    logic signed [Z_W-1:0]    op_b;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] resp_sum;
    logic signed [PROD_W-1:0] num_abs;
    logic signed [PROD_W-1:0] resp_abs;

    logic          degen_c;
    logic          last_k;
    logic [D_W:0]  r_sh;
    logic          ge;
    logic          ovf;
    logic [W1:0]   q_round;
    logic [W1-1:0] qh;
    logic [COEF_W-1:0] coef_c;

    always_comb
    begin
        px_s[0] = Z_W'({1'b0, regs[REG_RED_X]});
        py_s[0] = Z_W'({1'b0, regs[REG_RED_Y]});
        px_s[1] = Z_W'({1'b0, regs[REG_GREEN_X]});
        py_s[1] = Z_W'({1'b0, regs[REG_GREEN_Y]});
        px_s[2] = Z_W'({1'b0, regs[REG_BLUE_X]});
        py_s[2] = Z_W'({1'b0, regs[REG_BLUE_Y]});
        for (int p = 0; p < 3; p++)
        begin
            pz_s[p] = CHROMA_ONE - px_s[p] - py_s[p];
        end
        w_s[0] = Z_W'({1'b0, regs[REG_WHITE_X]});
        w_s[1] = Z_W'({1'b0, regs[REG_WHITE_Y]});
        w_s[2] = CHROMA_ONE - w_s[0] - w_s[1];
    end

    always_comb
    begin
        unique case (row_reg)
            2'd0:
            begin
                ia = 2'd1;
                ib = 2'd2;
            end
            2'd1:
            begin
                ia = 2'd2;
                ib = 2'd0;
            end
            default:
            begin
                ia = 2'd0;
                ib = 2'd1;
            end
        endcase
    end

    // Cofactor k is u[a]*v[b] - u[b]*v[a], with (u, v) chosen by the column.
    always_comb
    begin
        unique case (col_reg)
            2'd0:
            begin
                u_a = py_s[ia];
                u_b = py_s[ib];
                v_a = pz_s[ia];
                v_b = pz_s[ib];
            end
            2'd1:
            begin
                u_a = pz_s[ia];
                u_b = pz_s[ib];
                v_a = px_s[ia];
                v_b = px_s[ib];
            end
            default:
            begin
                u_a = px_s[ia];
                u_b = px_s[ib];
                v_a = py_s[ia];
                v_b = py_s[ib];
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            DER_COF:
            begin
                op_a = sub_reg ? COF_W'(u_b) : COF_W'(u_a);
                op_b = sub_reg ? v_a : v_b;
            end
            DER_RESP:
            begin
                op_a = cof_reg[k_reg];
                op_b = w_s[col_reg];
            end
            default:
            begin
                op_a = cof_reg[k_reg];
                op_b = w_s[1];
            end
        endcase
    end

    assign prod_c   = PROD_W'(op_a) * PROD_W'(op_b);
    assign resp_sum = ((col_reg == 2'd0) ? '0 : acc_reg) + prod_reg;
    assign num_abs  = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign resp_abs = resp_reg[row_reg][PROD_W-1] ? -resp_reg[row_reg] : resp_reg[row_reg];
    assign degen_c  = (w_s[1] == '0) || (resp_reg[0] == '0) || (resp_reg[1] == '0)
                      || (resp_reg[2] == '0);
    assign last_k   = (k_reg == K_W'(NUM_COEF - 1));

    assign r_sh = {rem_reg, nq_reg[NW-1]};
    assign ge   = (r_sh >= {1'b0, d_reg});

    assign ovf     = |nq_reg[NW-1:W1];
    assign q_round = {1'b0, nq_reg[W1-1:0]} + (W1+1)'(1);
    assign qh      = q_round[W1:1];

    always_comb
    begin
        if (neg_reg)
        begin
            coef_c = (ovf || (qh > NEG_LIM)) ? COEF_W'(32'h8000_0000) : -qh[COEF_W-1:0];
        end
        else
        begin
            coef_c = (ovf || (qh > POS_LIM)) ? COEF_W'(32'h7FFF_FFFF) : qh[COEF_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_wr)
        begin
            state_next = DER_COF;
        end
        else
        begin
            unique case (state_reg)
                DER_COF:   if (half_reg && sub_reg && last_k) state_next = DER_RESP;
                DER_RESP:  if (half_reg && last_k) state_next = DER_CHECK;
                DER_CHECK: state_next = degen_c ? DER_DONE : DER_NUM;
                DER_NUM:   if (half_reg) state_next = DER_DIV;
                DER_DIV:   if (bit_cnt_reg == CNT_W'(NW - 1)) state_next = DER_FIN;
                DER_FIN:   state_next = last_k ? DER_DONE : DER_NUM;
                default:   state_next = DER_DONE;
            endcase
        end
    end

    always_comb
    begin
        stat.busy       = (state_reg != DER_DONE);
        stat.degenerate = degen_reg;
    end

    assign matrix = coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DER_COF;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg       <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            sub_reg     <= 1'b0;
            half_reg    <= 1'b0;
            bit_cnt_reg <= '0;
            degen_reg   <= 1'b0;
        end
        else if (cfg_wr)
        begin
            k_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            sub_reg  <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                DER_COF, DER_RESP, DER_NUM, DER_FIN:
                begin
                    if (state_reg != DER_FIN)
                    begin
                        half_reg <= ~half_reg;
                    end
                    if (state_reg == DER_COF && half_reg)
                    begin
                        sub_reg <= ~sub_reg;
                    end
                    if (state_reg == DER_NUM)
                    begin
                        bit_cnt_reg <= '0;
                    end
                    if ((state_reg == DER_COF && half_reg && sub_reg)
                        || (state_reg == DER_RESP && half_reg) || state_reg == DER_FIN)
                    begin
                        if (last_k)
                        begin
                            k_reg   <= '0;
                            row_reg <= '0;
                            col_reg <= '0;
                        end
                        else
                        begin
                            k_reg <= k_reg + K_W'(1);
                            if (col_reg == 2'd2)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 2'd1;
                            end
                            else
                            begin
                                col_reg <= col_reg + 2'd1;
                            end
                        end
                    end
                end
                DER_CHECK:
                begin
                    degen_reg <= degen_c;
                end
                DER_DIV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + CNT_W'(1);
                end
                default:
                begin
                    half_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            DER_COF:
            begin
                if (!half_reg)
                begin
                    prod_reg <= prod_c;
                end
                else if (!sub_reg)
                begin
                    acc_reg <= prod_reg;
                end
                else
                begin
                    cof_reg[k_reg] <= COF_W'(acc_reg - prod_reg);
                end
            end
            DER_RESP:
            begin
                if (!half_reg)
                begin
                    prod_reg <= prod_c;
                end
                else
                begin
                    acc_reg <= resp_sum;
                    if (col_reg == 2'd2)
                    begin
                        resp_reg[row_reg] <= resp_sum;
                    end
                end
            end
            DER_NUM:
            begin
                if (!half_reg)
                begin
                    prod_reg <= prod_c;
                end
                else
                begin
                    nq_reg  <= {num_abs[A_W-1:0], (FRAC_BITS + 1)'(0)};
                    rem_reg <= '0;
                    d_reg   <= resp_abs[D_W-1:0];
                    neg_reg <= prod_reg[PROD_W-1] ^ resp_reg[row_reg][PROD_W-1];
                end
            end
            DER_DIV:
            begin
                rem_reg <= ge ? D_W'(r_sh - {1'b0, d_reg}) : r_sh[D_W-1:0];
                nq_reg  <= {nq_reg[NW-2:0], ge};
            end
            DER_FIN:
            begin
                coef_reg[k_reg] <= coef_c;
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

endmodule

FILE: hw/rtl/cxr_pipe.sv
// Three-stage conversion datapath: products, rounded sums, saturation and status.
// Depends on cxr_pkg.
module cxr_pipe
    import cxr_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  matrix_t                matrix,
    input  der_stat_t              stat,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [IN_W-1:0]        cie_x,
    input  logic [IN_W-1:0]        cie_y,
    input  logic [IN_W-1:0]        cie_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [OUT_W-1:0] red_out,
    output logic signed [OUT_W-1:0] green_out,
    output logic signed [OUT_W-1:0] blue_out,
    output status_t                status
);

    localparam int MP_W  = COEF_W + IN_W + 1;
    localparam int ACC_W = MP_W + 2;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(OUT_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(OUT_MIN);

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic adv1;
    logic adv2;
    logic adv3;

    logic [IN_W-1:0]         vin [3];
    logic signed [MP_W-1:0]  prod1_reg [NUM_COEF];
    logic signed [ACC_W-1:0] acc2_reg [3];
    logic signed [ACC_W-1:0] sh [3];
    logic signed [OUT_W-1:0] res [3];
    logic [2:0]              clip;
    logic signed [OUT_W-1:0] rgb_reg [3];
    status_t                 status_reg;

    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1 && !stat.busy;

    assign vin[0] = cie_x;
    assign vin[1] = cie_y;
    assign vin[2] = cie_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid && in_ready;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            for (int k = 0; k < NUM_COEF; k++)
            begin
                prod1_reg[k] <= MP_W'($signed(matrix[k])) * MP_W'($signed({1'b0, vin[k % 3]}));
            end
        end
        if (adv2)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc2_reg[c] <= ACC_W'(prod1_reg[3*c]) + ACC_W'(prod1_reg[3*c+1])
                               + ACC_W'(prod1_reg[3*c+2]) + ROUND_HALF;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sh[c]   = acc2_reg[c] >>> FRAC_BITS;
            clip[c] = (sh[c] > SAT_HI) || (sh[c] < SAT_LO);
            if (sh[c] > SAT_HI)
            begin
                res[c] = OUT_W'(OUT_MAX);
            end
            else if (sh[c] < SAT_LO)
            begin
                res[c] = OUT_W'(OUT_MIN);
            end
            else
            begin
                res[c] = sh[c][OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            for (int c = 0; c < 3; c++)
            begin
                rgb_reg[c] <= stat.degenerate ? '0 : res[c];
            end
            if (stat.degenerate)
            begin
                status_reg <= STATUS_DEGEN;
            end
            else
            begin
                status_reg <= (|clip) ? STATUS_SAT : STATUS_OK;
            end
        end
    end

    assign out_valid = v3_reg;
    assign red_out   = rgb_reg[0];
    assign green_out = rgb_reg[1];
    assign blue_out  = rgb_reg[2];
    assign status    = status_reg;

endmodule
